### sv/lup_pkg.sv
// Package for the lens undistortion point block.
// Holds shared types, codes, fixed-point constants and rounding helpers.
// No dependencies.
`default_nettype none

package lup_pkg;

    localparam int QBITS   = 32;
    localparam int DIV_LAT = QBITS + 3;
    localparam int NUM_W   = 48;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SCALE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic [2:0] REG_FOCAL_X    = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
    localparam logic [2:0] REG_CENTER_X   = 3'd2;
    localparam logic [2:0] REG_CENTER_Y   = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1  = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2  = 3'd5;
    localparam logic [2:0] REG_RADIAL_K3  = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL = 3'd7;

    localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

    localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
    localparam logic        [31:0] Q_NEG_LIM = 32'h8000_0000;

    localparam logic signed [47:0] MAX48     = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] MIN48     = 48'shFFFF_8000_0000;
    localparam logic signed [47:0] SCALE_ONE = 48'sh0000_1000_0000;

    typedef struct packed {
        logic        zero;
        logic        ovf;
        logic [31:0] x0;
        logic [31:0] y0;
    } t_side;

    typedef struct packed {
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
        logic [31:0] p1;
        logic [31:0] p2;
    } t_coef;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] res;
        if (v > MAX48) begin
            res = S32_MAX;
        end else if (v < MIN48) begin
            res = S32_MIN;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    function automatic logic is_sat32(input logic signed [47:0] v);
        return (v > MAX48) || (v < MIN48);
    endfunction

    // round to nearest, ties up, dropping 20 bits
    function automatic logic signed [47:0] rnd20(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = v + 65'sd524288;
        return 48'(t >>> 20);
    endfunction

    function automatic logic signed [47:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd8388608;
        return 48'(t >>> 24);
    endfunction

    function automatic logic signed [31:0] rnd32(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sh0000_0000_8000_0000;
        return 32'(t >>> 32);
    endfunction

endpackage

`default_nettype wire

### sv/lup_div.sv
// Pipelined signed divider: num * 2^28 / den, truncated, saturated to 32 bits.
// One quotient bit per stage; uses lup_pkg.
`default_nettype none

module lup_div #(
    parameter int NW = 48,
    parameter int DW = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic signed [DW-1:0] i_den,
    output logic                      o_valid,
    output logic signed [31:0]        o_quo,
    output logic                      o_ovf
);

    localparam int QB = lup_pkg::QBITS;
    localparam int CW = (NW > DW + 4) ? NW : DW + 4;

    logic          r_a_v, n_a_v;
    logic [NW-1:0] r_a_m, n_a_m;
    logic [DW-1:0] r_a_d, n_a_d;
    logic          r_a_neg, n_a_neg;

    logic          r_s_v    [QB+1];
    logic [DW-1:0] r_s_rem  [QB+1];
    logic [QB-1:0] r_s_q    [QB+1];
    logic [QB-1:0] r_s_low  [QB+1];
    logic [DW-1:0] r_s_d    [QB+1];
    logic          r_s_neg  [QB+1];
    logic          r_s_big  [QB+1];
    logic          r_s_mz   [QB+1];
    logic          n_s_v    [QB+1];
    logic [DW-1:0] n_s_rem  [QB+1];
    logic [QB-1:0] n_s_q    [QB+1];
    logic [QB-1:0] n_s_low  [QB+1];
    logic [DW-1:0] n_s_d    [QB+1];
    logic          n_s_neg  [QB+1];
    logic          n_s_big  [QB+1];
    logic          n_s_mz   [QB+1];

    logic               r_o_v, n_o_v;
    logic signed [31:0] r_o_quo, n_o_quo;
    logic               r_o_ovf, n_o_ovf;

    always_comb begin
        n_a_v   = i_valid;
        n_a_m   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_a_d   = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
        n_a_neg = i_num[NW-1] ^ i_den[DW-1];
    end

    always_comb begin
        logic [CW-1:0] m_ext;
        logic [CW-1:0] d16;
        logic [DW:0]   sh;
        m_ext      = CW'(r_a_m);
        d16        = CW'({r_a_d, 4'b0000});
        n_s_v[0]   = r_a_v;
        n_s_rem[0] = DW'(m_ext >> 4);
        n_s_q[0]   = '0;
        n_s_low[0] = {r_a_m[3:0], {(QB-4){1'b0}}};
        n_s_d[0]   = r_a_d;
        n_s_neg[0] = r_a_neg;
        n_s_big[0] = m_ext >= d16;
        n_s_mz[0]  = r_a_m == '0;
        for (int k = 0; k < QB; k++) begin
            sh           = {r_s_rem[k], r_s_low[k][QB-1]};
            n_s_v[k+1]   = r_s_v[k];
            n_s_low[k+1] = {r_s_low[k][QB-2:0], 1'b0};
            n_s_d[k+1]   = r_s_d[k];
            n_s_neg[k+1] = r_s_neg[k];
            n_s_big[k+1] = r_s_big[k];
            n_s_mz[k+1]  = r_s_mz[k];
            if (sh >= {1'b0, r_s_d[k]}) begin
                n_s_rem[k+1] = DW'(sh - {1'b0, r_s_d[k]});
                n_s_q[k+1]   = {r_s_q[k][QB-2:0], 1'b1};
            end else begin
                n_s_rem[k+1] = sh[DW-1:0];
                n_s_q[k+1]   = {r_s_q[k][QB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [QB-1:0] q;
        q     = r_s_q[QB];
        n_o_v = r_s_v[QB];
        if (r_s_mz[QB]) begin
            n_o_quo = '0;
            n_o_ovf = 1'b0;
        end else if (r_s_big[QB]) begin
            n_o_quo = r_s_neg[QB] ? lup_pkg::S32_MIN : lup_pkg::S32_MAX;
            n_o_ovf = 1'b1;
        end else if (r_s_neg[QB]) begin
            if (q > lup_pkg::Q_NEG_LIM) begin
                n_o_quo = lup_pkg::S32_MIN;
                n_o_ovf = 1'b1;
            end else begin
                n_o_quo = signed'(32'(-q));
                n_o_ovf = 1'b0;
            end
        end else if (q[QB-1]) begin
            n_o_quo = lup_pkg::S32_MAX;
            n_o_ovf = 1'b1;
        end else begin
            n_o_quo = signed'(q);
            n_o_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_s_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_a_v <= n_a_v;
            r_o_v <= n_o_v;
            for (int k = 0; k <= QB; k++) begin
                r_s_v[k] <= n_s_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_m   <= n_a_m;
            r_a_d   <= n_a_d;
            r_a_neg <= n_a_neg;
            r_o_quo <= n_o_quo;
            r_o_ovf <= n_o_ovf;
            for (int k = 0; k <= QB; k++) begin
                r_s_rem[k] <= n_s_rem[k];
                r_s_q[k]   <= n_s_q[k];
                r_s_low[k] <= n_s_low[k];
                r_s_d[k]   <= n_s_d[k];
                r_s_neg[k] <= n_s_neg[k];
                r_s_big[k] <= n_s_big[k];
                r_s_mz[k]  <= n_s_mz[k];
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_quo   = r_o_quo;
    assign o_ovf   = r_o_ovf;

endmodule

`default_nettype wire

### sv/lup_iter.sv
// One fixed-point refinement step of the undistortion: radius powers,
// radial scale, tangential terms, then two divisions. Uses lup_pkg, lup_div.
`default_nettype none

module lup_iter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire lup_pkg::t_coef     i_coef,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    input  wire lup_pkg::t_side     i_side,
    output logic                    o_valid,
    output logic signed [31:0]      o_x,
    output logic signed [31:0]      o_y,
    output lup_pkg::t_side          o_side
);

    localparam int NW = lup_pkg::NUM_W;

    logic signed [31:0] c_k1, c_k2, c_k3, c_p1, c_p2;
    assign c_k1 = signed'(i_coef.k1);
    assign c_k2 = signed'(i_coef.k2);
    assign c_k3 = signed'(i_coef.k3);
    assign c_p1 = signed'(i_coef.p1);
    assign c_p2 = signed'(i_coef.p2);

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    lup_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side, r7_side, r8_side;
    lup_pkg::t_side n2_side, n4_side, n6_side, n8_side;

    logic signed [63:0] r1_xx, r1_yy, r1_xy;
    logic signed [31:0] r2_x2, r2_y2, r2_xy, r2_r2, n2_x2, n2_y2, n2_xy, n2_r2;
    logic signed [63:0] r3_prr, r3_pk1, r3_pa, r3_pb, r3_pc, r3_pd, r3_pe, r3_pf;
    logic signed [31:0] r3_r2;
    logic signed [31:0] r4_r4, r4_r2, n4_r4;
    logic signed [47:0] r4_tk1, r4_ta, r4_tb, r4_tc, r4_td, r4_te, r4_tf;
    logic signed [63:0] r5_prr, r5_pk2;
    logic signed [47:0] r5_tk1, r5_sx, r5_sy;
    logic signed [31:0] r6_r6, n6_r6;
    logic signed [47:0] r6_tk1, r6_tk2, r6_sx, r6_sy;
    logic signed [63:0] r7_pk3;
    logic signed [47:0] r7_tk1, r7_tk2, r7_sx, r7_sy;
    logic signed [NW-1:0] r8_scale, r8_numx, r8_numy, n8_scale;

    lup_pkg::t_side r_dl [lup_pkg::DIV_LAT];

    always_comb begin
        logic signed [47:0] sum;
        logic signed [47:0] p4;
        logic signed [47:0] p6;
        n2_x2 = lup_pkg::rnd32(r1_xx);
        n2_y2 = lup_pkg::rnd32(r1_yy);
        n2_xy = lup_pkg::rnd32(r1_xy);
        sum   = 48'(n2_x2) + 48'(n2_y2);
        n2_r2 = lup_pkg::sat32(sum);
        n2_side     = r1_side;
        n2_side.ovf = r1_side.ovf | lup_pkg::is_sat32(sum);

        p4    = lup_pkg::rnd24(r3_prr);
        n4_r4 = lup_pkg::sat32(p4);
        n4_side     = r3_side;
        n4_side.ovf = r3_side.ovf | lup_pkg::is_sat32(p4);

        p6    = lup_pkg::rnd24(r5_prr);
        n6_r6 = lup_pkg::sat32(p6);
        n6_side     = r5_side;
        n6_side.ovf = r5_side.ovf | lup_pkg::is_sat32(p6);

        n8_scale     = lup_pkg::SCALE_ONE + r7_tk1 + r7_tk2 + lup_pkg::rnd20(65'(r7_pk3));
        n8_side      = r7_side;
        n8_side.zero = r7_side.zero | (n8_scale == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xx   <= 64'(i_x) * 64'(i_x);
            r1_yy   <= 64'(i_y) * 64'(i_y);
            r1_xy   <= 64'(i_x) * 64'(i_y);
            r1_side <= i_side;

            r2_x2   <= n2_x2;
            r2_y2   <= n2_y2;
            r2_xy   <= n2_xy;
            r2_r2   <= n2_r2;
            r2_side <= n2_side;

            r3_prr  <= 64'(r2_r2) * 64'(r2_r2);
            r3_pk1  <= 64'(c_k1) * 64'(r2_r2);
            r3_pa   <= 64'(c_p1) * 64'(r2_xy);
            r3_pb   <= 64'(c_p2) * 64'(r2_r2);
            r3_pc   <= 64'(c_p2) * 64'(r2_x2);
            r3_pd   <= 64'(c_p1) * 64'(r2_r2);
            r3_pe   <= 64'(c_p1) * 64'(r2_y2);
            r3_pf   <= 64'(c_p2) * 64'(r2_xy);
            r3_r2   <= r2_r2;
            r3_side <= r2_side;

            r4_r4   <= n4_r4;
            r4_r2   <= r3_r2;
            r4_tk1  <= lup_pkg::rnd20(65'(r3_pk1));
            r4_ta   <= lup_pkg::rnd20(signed'({r3_pa, 1'b0}));
            r4_tb   <= lup_pkg::rnd20(65'(r3_pb));
            r4_tc   <= lup_pkg::rnd20(signed'({r3_pc, 1'b0}));
            r4_td   <= lup_pkg::rnd20(65'(r3_pd));
            r4_te   <= lup_pkg::rnd20(signed'({r3_pe, 1'b0}));
            r4_tf   <= lup_pkg::rnd20(signed'({r3_pf, 1'b0}));
            r4_side <= n4_side;

            r5_prr  <= 64'(r4_r4) * 64'(r4_r2);
            r5_pk2  <= 64'(c_k2) * 64'(r4_r4);
            r5_tk1  <= r4_tk1;
            r5_sx   <= r4_ta + r4_tb + r4_tc;
            r5_sy   <= r4_td + r4_te + r4_tf;
            r5_side <= r4_side;

            r6_r6   <= n6_r6;
            r6_tk1  <= r5_tk1;
            r6_tk2  <= lup_pkg::rnd20(65'(r5_pk2));
            r6_sx   <= r5_sx;
            r6_sy   <= r5_sy;
            r6_side <= n6_side;

            r7_pk3  <= 64'(c_k3) * 64'(r6_r6);
            r7_tk1  <= r6_tk1;
            r7_tk2  <= r6_tk2;
            r7_sx   <= r6_sx;
            r7_sy   <= r6_sy;
            r7_side <= r6_side;

            r8_scale <= n8_scale;
            r8_numx  <= NW'(signed'(r7_side.x0)) - r7_sx;
            r8_numy  <= NW'(signed'(r7_side.y0)) - r7_sy;
            r8_side  <= n8_side;

            r_dl[0] <= r8_side;
            for (int k = 1; k < lup_pkg::DIV_LAT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    logic               w_vx, w_vy, w_ox, w_oy;
    logic signed [31:0] w_qx, w_qy;

    lup_div #(.NW(NW), .DW(NW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r8_v),
        .i_num   (r8_numx),
        .i_den   (r8_scale),
        .o_valid (w_vx),
        .o_quo   (w_qx),
        .o_ovf   (w_ox)
    );

    lup_div #(.NW(NW), .DW(NW)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r8_v),
        .i_num   (r8_numy),
        .i_den   (r8_scale),
        .o_valid (w_vy),
        .o_quo   (w_qy),
        .o_ovf   (w_oy)
    );

    always_comb begin
        o_side     = r_dl[lup_pkg::DIV_LAT-1];
        o_side.ovf = r_dl[lup_pkg::DIV_LAT-1].ovf | w_ox | w_oy;
    end

    assign o_valid = w_vx & w_vy;
    assign o_x     = w_qx;
    assign o_y     = w_qy;

endmodule

`default_nettype wire

### sv/lens_undistort_point.sv
// Lens undistortion of one pixel point per beat, Brown-Conrady model.
// Top level: configuration registers, normalisation, iteration chain,
// pixel mapping and output buffer. Uses lup_pkg, lup_div, lup_iter.
//
// Input beat on i_s_*: tdata = {point_y_in, point_x_in}, Q16.16 pixels.
// Output beat on o_m_*: tdata = {pad, status, point_y_out, point_x_out}.
// Status: 0 ok, 1 radial scale zero (point forced to 0), 2 saturated.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr;
// write only while no beat is in flight.
// Fully pipelined: one point accepted per clock while the output buffer
// is not full. Latency is dominated by the 35-stage one-bit-per-stage
// dividers in each iteration and in normalisation.
// A two-beat output buffer takes results; the whole pipeline advances
// only while that buffer is not full, so a stalled receiver holds every
// beat in place and o_s_tready falls once two results wait.
// Synchronous reset clears all valid bits and the buffer and loads the
// register defaults (unit focal lengths, all else zero).
`default_nettype none

module lens_undistort_point #(
    parameter int ITERATIONS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // point_x_in, point_y_in
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // point_x_out, point_y_out, status
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [63:0] i_cfg_wdata
);

    logic [31:0]        r_focal_x, r_focal_y;
    logic signed [31:0] r_center_x, r_center_y;
    logic [31:0]        r_k1, r_k2, r_k3;
    logic [63:0]        r_tang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= lup_pkg::FOCAL_RESET;
            r_focal_y  <= lup_pkg::FOCAL_RESET;
            r_center_x <= '0;
            r_center_y <= '0;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_tang     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lup_pkg::REG_FOCAL_X:    r_focal_x  <= i_cfg_wdata[31:0];
                lup_pkg::REG_FOCAL_Y:    r_focal_y  <= i_cfg_wdata[31:0];
                lup_pkg::REG_CENTER_X:   r_center_x <= signed'(i_cfg_wdata[31:0]);
                lup_pkg::REG_CENTER_Y:   r_center_y <= signed'(i_cfg_wdata[31:0]);
                lup_pkg::REG_RADIAL_K1:  r_k1       <= i_cfg_wdata[31:0];
                lup_pkg::REG_RADIAL_K2:  r_k2       <= i_cfg_wdata[31:0];
                lup_pkg::REG_RADIAL_K3:  r_k3       <= i_cfg_wdata[31:0];
                lup_pkg::REG_TANGENTIAL: r_tang     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lup_pkg::t_coef w_coef;
    always_comb begin
        w_coef.k1 = r_k1;
        w_coef.k2 = r_k2;
        w_coef.k3 = r_k3;
        w_coef.p1 = r_tang[31:0];
        w_coef.p2 = r_tang[63:32];
    end

    logic [1:0]  r_cnt, n_cnt;
    logic [65:0] r_buf0, r_buf1, n_buf0, n_buf1;
    logic        w_en, w_push, w_pop;
    logic [65:0] w_beat;

    assign w_en       = ~r_cnt[1];
    assign o_s_tready = w_en;

    // normalisation
    logic               r_n_v;
    logic signed [32:0] r_n_x, r_n_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (w_en) begin
            r_n_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_x <= 33'(signed'(i_s_tdata[31:0])) - 33'(r_center_x);
            r_n_y <= 33'(signed'(i_s_tdata[63:32])) - 33'(r_center_y);
        end
    end

    logic               w_nx_v, w_ny_v, w_nx_o, w_ny_o;
    logic signed [31:0] w_x0, w_y0;

    lup_div #(.NW(33), .DW(33)) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_v),
        .i_num   (r_n_x),
        .i_den   ({1'b0, r_focal_x}),
        .o_valid (w_nx_v),
        .o_quo   (w_x0),
        .o_ovf   (w_nx_o)
    );

    lup_div #(.NW(33), .DW(33)) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_v),
        .i_num   (r_n_y),
        .i_den   ({1'b0, r_focal_y}),
        .o_valid (w_ny_v),
        .o_quo   (w_y0),
        .o_ovf   (w_ny_o)
    );

    // iteration chain
    logic               w_it_v    [ITERATIONS+1];
    logic signed [31:0] w_it_x    [ITERATIONS+1];
    logic signed [31:0] w_it_y    [ITERATIONS+1];
    lup_pkg::t_side     w_it_side [ITERATIONS+1];

    always_comb begin
        w_it_v[0]         = w_nx_v & w_ny_v;
        w_it_x[0]         = w_x0;
        w_it_y[0]         = w_y0;
        w_it_side[0].zero = 1'b0;
        w_it_side[0].ovf  = w_nx_o | w_ny_o;
        w_it_side[0].x0   = w_x0;
        w_it_side[0].y0   = w_y0;
    end

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        lup_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_coef  (w_coef),
            .i_valid (w_it_v[g]),
            .i_x     (w_it_x[g]),
            .i_y     (w_it_y[g]),
            .i_side  (w_it_side[g]),
            .o_valid (w_it_v[g+1]),
            .o_x     (w_it_x[g+1]),
            .o_y     (w_it_y[g+1]),
            .o_side  (w_it_side[g+1])
        );
    end

    // map back to pixels
    logic               r_f_v;
    logic signed [64:0] r_f_px, r_f_py;
    lup_pkg::t_side     r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_it_v[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_px   <= 65'(signed'({1'b0, r_focal_x})) * 65'(w_it_x[ITERATIONS]);
            r_f_py   <= 65'(signed'({1'b0, r_focal_y})) * 65'(w_it_y[ITERATIONS]);
            r_f_side <= w_it_side[ITERATIONS];
        end
    end

    always_comb begin
        logic signed [64:0] tx;
        logic signed [64:0] ty;
        logic signed [47:0] sx;
        logic signed [47:0] sy;
        logic [1:0]         st;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        tx = r_f_px + 65'sd134217728;
        ty = r_f_py + 65'sd134217728;
        sx = 48'(tx >>> 28) + 48'(r_center_x);
        sy = 48'(ty >>> 28) + 48'(r_center_y);
        ox = lup_pkg::sat32(sx);
        oy = lup_pkg::sat32(sy);
        if (r_f_side.zero) begin
            st = lup_pkg::STATUS_SCALE;
            ox = '0;
            oy = '0;
        end else if (r_f_side.ovf || lup_pkg::is_sat32(sx) || lup_pkg::is_sat32(sy)) begin
            st = lup_pkg::STATUS_SAT;
        end else begin
            st = lup_pkg::STATUS_OK;
        end
        w_beat = {st, oy, ox};
    end

    // output buffer, two beats deep
    assign w_push = w_en & r_f_v;
    assign w_pop  = o_m_tvalid & i_m_tready;

    always_comb begin
        n_cnt  = r_cnt;
        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        case ({w_push, w_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_buf0 = w_beat;
                end else begin
                    n_buf1 = w_beat;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_buf0 = r_buf1;
                n_cnt  = r_cnt - 2'd1;
            end
            2'b11: begin
                n_buf0 = w_beat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

    assign o_m_tvalid = r_cnt != 2'd0;
    assign o_m_tdata  = {6'd0, r_buf0};

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !w_push)
        else $error("push into full output buffer");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push && r_cnt == 2'd1) |=> (r_cnt == 2'd0))
        else $error("output buffer failed to drain");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[65:64] == lup_pkg::STATUS_OK ||
                        o_m_tdata[65:64] == lup_pkg::STATUS_SCALE ||
                        o_m_tdata[65:64] == lup_pkg::STATUS_SAT))
        else $error("bad status code");

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[65:64] == lup_pkg::STATUS_SCALE) |->
        (o_m_tdata[63:0] == 64'd0))
        else $error("scale failure without zero point");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for lens_undistort_point: drives points over the stream input,
// predicts each undistorted point and status in fixed point, checks beats.
// Depends on lup_pkg and the lens_undistort_point RTL.
`default_nettype none

module tb_top;

    localparam int LATENCY  = 38 + 43 * 10;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] py;
        logic [31:0] px;
    } t_point_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [63:0] i_cfg_wdata = '0;

    lens_undistort_point u_dut (.*);

    // lens parameters as held by the block
    logic [31:0] lens_fx, lens_fy, lens_cx, lens_cy, lens_k1, lens_k2, lens_k3;
    logic [63:0] lens_tan;

    t_point_res undist_q[$];
    int errors = 0;
    int n_sent = 0, n_rcvd = 0, n_scale = 0, n_sat = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic longint rshift_rnd(longint v, int n);
        longint t;
        t = v + (longint'(1) << (n - 1));
        return t >>> n;
    endfunction

    function automatic longint clamp32(longint v, inout bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint q28_divide(longint num, longint den, inout bit ovf);
        bit neg;
        logic [63:0] m, d, q, r, f, total;
        neg = (num < 0) != (den < 0);
        m = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        f = 0;
        if (m == 0) return 0;
        if (d == 0) begin
            ovf = 1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        q = m / d;
        r = m % d;
        if (q > 8) begin
            ovf = 1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        for (int i = 0; i < 28; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= d) begin
                r = r - d;
                f[0] = 1'b1;
            end
        end
        total = (q << 28) | f;
        if (neg) begin
            if (total > 64'h8000_0000) begin
                ovf = 1;
                return -64'sd2147483648;
            end
            return -longint'(total);
        end
        if (total > 64'h7FFF_FFFF) begin
            ovf = 1;
            return 64'sd2147483647;
        end
        return longint'(total);
    endfunction

    function automatic t_point_res undistort(logic [31:0] pxi, logic [31:0] pyi);
        t_point_res res;
        bit ovf;
        longint fx, fy, cx, cy, k1, k2, k3, p1, p2, x0, y0, x, y;
        longint x2, y2, xy, r2, r4, r6, sc, tx, ty;
        ovf = 0;
        fx = longint'({32'd0, lens_fx});
        fy = longint'({32'd0, lens_fy});
        cx = longint'(signed'(lens_cx));
        cy = longint'(signed'(lens_cy));
        k1 = longint'(signed'(lens_k1));
        k2 = longint'(signed'(lens_k2));
        k3 = longint'(signed'(lens_k3));
        p1 = longint'(signed'(lens_tan[31:0]));
        p2 = longint'(signed'(lens_tan[63:32]));
        x0 = q28_divide(longint'(signed'(pxi)) - cx, fx, ovf);
        y0 = q28_divide(longint'(signed'(pyi)) - cy, fy, ovf);
        x = x0;
        y = y0;
        for (int it = 0; it < 10; it++) begin
            x2 = rshift_rnd(x * x, 32);
            y2 = rshift_rnd(y * y, 32);
            xy = rshift_rnd(x * y, 32);
            r2 = clamp32(x2 + y2, ovf);
            r4 = clamp32(rshift_rnd(r2 * r2, 24), ovf);
            r6 = clamp32(rshift_rnd(r4 * r2, 24), ovf);
            sc = (longint'(1) << 28) + rshift_rnd(k1 * r2, 20)
                 + rshift_rnd(k2 * r4, 20) + rshift_rnd(k3 * r6, 20);
            if (sc == 0) begin
                res.px = '0;
                res.py = '0;
                res.st = lup_pkg::STATUS_SCALE;
                return res;
            end
            tx = rshift_rnd(2 * p1 * xy, 20) + rshift_rnd(p2 * r2, 20)
                 + rshift_rnd(2 * p2 * x2, 20);
            ty = rshift_rnd(p1 * r2, 20) + rshift_rnd(2 * p1 * y2, 20)
                 + rshift_rnd(2 * p2 * xy, 20);
            x = q28_divide(x0 - tx, sc, ovf);
            y = q28_divide(y0 - ty, sc, ovf);
        end
        res.px = 32'(clamp32(rshift_rnd(fx * x, 28) + cx, ovf));
        res.py = 32'(clamp32(rshift_rnd(fy * y, 28) + cy, ovf));
        res.st = ovf ? lup_pkg::STATUS_SAT : lup_pkg::STATUS_OK;
        return res;
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_point_res got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[65:0];
            n_rcvd++;
            if (undist_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat %h", $time, got);
            end else begin
                exp_r = undist_q.pop_front();
                if (got.st == lup_pkg::STATUS_SCALE) n_scale++;
                if (got.st == lup_pkg::STATUS_SAT) n_sat++;
                if (got.px !== exp_r.px) begin
                    errors++;
                    $display("%0t: x exp %h got %h", $time, exp_r.px, got.px);
                end
                if (got.py !== exp_r.py) begin
                    errors++;
                    $display("%0t: y exp %h got %h", $time, exp_r.py, got.py);
                end
                if (got.st !== exp_r.st) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, exp_r.st, got.st);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high after the beat; drain() or an idle wait in the next call drops it
    task automatic send_point(logic [31:0] pxi, logic [31:0] pyi);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {pyi, pxi};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        undist_q.push_back(undistort(pxi, pyi));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (undist_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        case (idx)
            lup_pkg::REG_FOCAL_X:    lens_fx = val[31:0];
            lup_pkg::REG_FOCAL_Y:    lens_fy = val[31:0];
            lup_pkg::REG_CENTER_X:   lens_cx = val[31:0];
            lup_pkg::REG_CENTER_Y:   lens_cy = val[31:0];
            lup_pkg::REG_RADIAL_K1:  lens_k1 = val[31:0];
            lup_pkg::REG_RADIAL_K2:  lens_k2 = val[31:0];
            lup_pkg::REG_RADIAL_K3:  lens_k3 = val[31:0];
            lup_pkg::REG_TANGENTIAL: lens_tan = val;
            default: ;
        endcase
    endtask

    task automatic set_lens(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                            logic [31:0] cy, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3, logic [63:0] tan);
        write_reg(lup_pkg::REG_FOCAL_X, {32'd0, fx});
        write_reg(lup_pkg::REG_FOCAL_Y, {32'd0, fy});
        write_reg(lup_pkg::REG_CENTER_X, {32'd0, cx});
        write_reg(lup_pkg::REG_CENTER_Y, {32'd0, cy});
        write_reg(lup_pkg::REG_RADIAL_K1, {32'd0, k1});
        write_reg(lup_pkg::REG_RADIAL_K2, {32'd0, k2});
        write_reg(lup_pkg::REG_RADIAL_K3, {32'd0, k3});
        write_reg(lup_pkg::REG_TANGENTIAL, tan);
        i_cfg_we <= 1'b0;
    endtask

    // mild lens: focal around 500..2000 px, small coefficients
    task automatic set_typical_lens();
        set_lens({16'($urandom_range(500, 2000)), 16'($urandom)},
                 {16'($urandom_range(500, 2000)), 16'($urandom)},
                 {16'($urandom_range(0, 1000)), 16'($urandom)},
                 {16'($urandom_range(0, 1000)), 16'($urandom)},
                 32'(int'($urandom_range(0, 8388608)) - 4194304),
                 32'(int'($urandom_range(0, 2097152)) - 1048576),
                 32'(int'($urandom_range(0, 1048576)) - 524288),
                 {32'(int'($urandom_range(0, 65536)) - 32768),
                  32'(int'($urandom_range(0, 65536)) - 32768)});
    endtask

    task automatic test_directed();
        logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h0001_0000};
        // reset values: identity mapping
        foreach (edges[i]) send_point(edges[i], edges[5 - i]);
        drain();
        // zero radial scale: k1 = -1, unit radius point
        set_lens(32'h0001_0000, 32'h0001_0000, 0, 0, 32'hFF00_0000, 0, 0, 0);
        send_point(32'h0001_0000, 32'h0);
        send_point(32'h0, 32'hFFFF_0000);
        drain();
        // zero focal length: zero and non-zero numerators
        set_lens(0, 0, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0);
        send_point(32'h0000_8000, 32'h0000_8000);
        send_point(32'h0001_0000, 32'h0000_0000);
        drain();
        // extreme coefficients and focal lengths
        set_lens(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 64'h8000_0000_7FFF_FFFF);
        foreach (edges[i]) send_point(edges[i], edges[(i + 2) % 6]);
        drain();
        set_lens(32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 64'h7FFF_FFFF_8000_0000);
        foreach (edges[i]) send_point(edges[i], edges[(i + 3) % 6]);
        drain();
    endtask

    task automatic random_points(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
                send_point($urandom, $urandom);
            end else begin
                send_point(signed'(lens_cx) + int'($urandom_range(0, 32'h0800_0000))
                           - 32'h0400_0000,
                           signed'(lens_cy) + int'($urandom_range(0, 32'h0800_0000))
                           - 32'h0400_0000);
            end
        end
    endtask

    task automatic test_random_phases();
        int recv_pct[4] = '{0, 0, 83, 23};
        int send_pct[4] = '{0, 83, 0, 23};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 2 == 0) begin
                set_typical_lens();
            end else begin
                set_lens($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, {$urandom, $urandom});
            end
            send_idle = send_pct[ph % 4];
            recv_idle = recv_pct[ph % 4];
            random_points(150);
            drain();
        end
        send_idle = 0;
        recv_idle = 0;
    endtask

    task automatic test_backpressure();
        set_typical_lens();
        // more points than the pipeline holds, so the input stalls
        fork
            begin
                hold_off = 1;
                repeat (800) @(negedge i_clk);
                hold_off = 0;
            end
            begin
                random_points(600);
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        join
        drain();
        // sender pause with everything drained, then resume
        random_points(30);
        drain();
    endtask

    initial begin
        lens_fx = lup_pkg::FOCAL_RESET;
        lens_fy = lup_pkg::FOCAL_RESET;
        {lens_cx, lens_cy, lens_k1, lens_k2, lens_k3} = '0;
        lens_tan = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        while (undist_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("Sent %0d points, checked %0d results (%0d scale-zero, %0d saturated)",
                 n_sent, n_rcvd, n_scale, n_sat);
        $display("across reset, extreme, typical and random lens settings with stalls.");
        if (errors == 0 && undist_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
